### rtl/frli_pkg.sv
`default_nettype none

package frli_pkg;

	// Field widths fixed by the port definition.
	localparam int SLOT_W  = 10;
	localparam int SEQ_W   = 32;
	localparam int MODE_W  = 2;
	localparam int COUNT_W = 11;
	localparam int SECT_W  = 6;

	// Sector count after reset.
	localparam logic [SECT_W-1:0] SECT_RESET = 6'd28;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIND    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

	localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = '1;
	localparam logic [SEQ_W-1:0] SEQ_FIRST    = 32'd1;

	// Control from the sequencer to the scan accumulator.
	typedef struct packed {
		logic start;
		logic take;
	} scan_ctl_t;

	// Next sequence number; zero is never issued, so the wrap goes to one.
	function automatic logic [SEQ_W-1:0] seq_after(input logic [SEQ_W-1:0] s);
		seq_after = (s == SEQ_ALL_ONES) ? SEQ_FIRST : s + SEQ_W'(1);
	endfunction

endpackage

`default_nettype wire

### rtl/frli_if.sv
`default_nettype none

// Request channel: one operation per transfer.
interface frli_req_if;
	logic                        valid;
	logic                        ready;
	logic [frli_pkg::MODE_W-1:0] mode;
	logic [frli_pkg::SLOT_W-1:0] slot_index;
	logic [frli_pkg::SEQ_W-1:0]  sequence_value;
	logic                        slot_blank;

	modport source (output valid, mode, slot_index, sequence_value, slot_blank,
		input ready);
	modport sink (input valid, mode, slot_index, sequence_value, slot_blank,
		output ready);
endinterface

// Response channel: one result per transfer.
interface frli_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [frli_pkg::SLOT_W-1:0]  result_slot;
	logic [frli_pkg::SEQ_W-1:0]   result_sequence;
	logic                         erase_needed;
	logic                         found;
	logic [frli_pkg::COUNT_W-1:0] valid_count;
	logic [frli_pkg::SEQ_W-1:0]   min_sequence;
	logic [frli_pkg::SEQ_W-1:0]   max_sequence;

	modport source (output valid, result_slot, result_sequence, erase_needed, found,
		valid_count, min_sequence, max_sequence, input ready);
	modport sink (input valid, result_slot, result_sequence, erase_needed, found,
		valid_count, min_sequence, max_sequence, output ready);
endinterface

// Configuration write channel for the sector count.
interface frli_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [frli_pkg::SECT_W-1:0] sector_count;

	modport source (output valid, sector_count, input ready);
	modport sink (input valid, sector_count, output ready);
endinterface

`default_nettype wire

### rtl/frli_scan.sv
`default_nettype none

// Accumulates count, oldest, newest and the find-after match over a table sweep.
module frli_scan #(
	parameter int AW = 10,
	parameter int NW = 11
) (
	input  wire logic                       clk,
	input  wire frli_pkg::scan_ctl_t        ctl,
	input  wire logic [frli_pkg::SEQ_W-1:0] data,
	input  wire logic [AW-1:0]              idx,
	input  wire logic [frli_pkg::SEQ_W-1:0] bound,
	output logic      [NW-1:0]              count,
	output logic      [frli_pkg::SEQ_W-1:0] oldest,
	output logic      [frli_pkg::SEQ_W-1:0] latest,
	output logic      [frli_pkg::SEQ_W-1:0] find_seq,
	output logic      [AW-1:0]              find_slot
);

	logic [NW-1:0]              count_q;
	logic [frli_pkg::SEQ_W-1:0] oldest_q;
	logic [frli_pkg::SEQ_W-1:0] latest_q;
	logic [frli_pkg::SEQ_W-1:0] find_seq_q;
	logic [AW-1:0]              find_slot_q;

	// One table entry per cycle while take is set; the start pulse clears everything for a new sweep.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			count_q     <= '0;
			oldest_q    <= '0;
			latest_q    <= '0;
			find_seq_q  <= '0;
			find_slot_q <= '0;
		end else if (ctl.take) begin
			if (data != '0) begin
				count_q <= count_q + NW'(1);
				if ((oldest_q == '0) || (data < oldest_q)) begin
					oldest_q <= data;
				end
				if (data > latest_q) begin
					latest_q <= data;
				end
			end
			// Keep the smallest sequence above the bound; the first one wins ties.
			if ((data > bound) && ((find_seq_q == '0) || (data < find_seq_q))) begin
				find_seq_q  <= data;
				find_slot_q <= idx;
			end
		end
	end

	assign count     = count_q;
	assign oldest    = oldest_q;
	assign latest    = latest_q;
	assign find_seq  = find_seq_q;
	assign find_slot = find_slot_q;

endmodule

`default_nettype wire

### rtl/flash_ring_log_index_unit.sv
// Steps: find, restore and no-op pass from the request transfer through preparation, a sweep
// of the slots in use and a drain step to the result; append adds the slot write before the
// sweep and, when a sector erase is flagged, an erase walk (up to SLOTS_PER_SECTOR entries)
// before that write. A stalled result adds its wait. One operation at a time: the next request
// is taken after the result is presented. Reset: control state takes its reset values,
// then a pass over all MAX_SLOTS entries zeroes the table.
`default_nettype none

module flash_ring_log_index_unit #(
	parameter int MAX_SLOTS        = 1024,
	parameter int SLOTS_PER_SECTOR = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	frli_req_if.sink    req,
	frli_rsp_if.source  rsp,
	frli_cfg_if.sink    cfg
);

	localparam int AW  = $clog2(MAX_SLOTS);
	localparam int NW  = $clog2(MAX_SLOTS + 1);
	localparam int OW  = $clog2(SLOTS_PER_SECTOR);
	localparam int SPW = $clog2(SLOTS_PER_SECTOR + 1);
	localparam int XW  = (NW > frli_pkg::SLOT_W) ? NW : frli_pkg::SLOT_W;
	localparam int PW0 = frli_pkg::SECT_W + SPW;
	localparam int PW  = (PW0 > NW) ? PW0 : NW;
	localparam int JW  = ((NW > SPW) ? NW : SPW) + 1;

	localparam logic [OW-1:0] OFF_LAST   = OW'(SLOTS_PER_SECTOR - 1);
	localparam logic [AW-1:0] CLEAR_LAST = AW'(MAX_SLOTS - 1);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_ERASE = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;

	// Control state.
	logic [frli_pkg::SECT_W-1:0] sect_q;
	logic [AW-1:0]               next_slot_q;
	logic [OW-1:0]               off_q;
	logic [frli_pkg::SEQ_W-1:0]  next_seq_q;
	logic [frli_pkg::SEQ_W-1:0]  newest_q;
	logic [AW-1:0]               scan_q;
	logic [OW-1:0]               off_run_q;
	logic [OW-1:0]               clr_q;
	logic                        take_s1;
	logic                        rsp_valid_q;

	// Captured request and append working values.
	logic [frli_pkg::MODE_W-1:0] mode_q;
	logic [frli_pkg::SLOT_W-1:0] sidx_q;
	logic [frli_pkg::SEQ_W-1:0]  val_q;
	logic                        blank_q;
	logic [AW-1:0]               wslot_q;
	logic                        erase_q;
	logic [frli_pkg::SEQ_W-1:0]  aseq_q;
	logic [frli_pkg::SEQ_W-1:0]  rd_s1;
	logic [AW-1:0]               idx_s1;

	// Output registers.
	logic [frli_pkg::SLOT_W-1:0]  out_slot_q;
	logic [frli_pkg::SEQ_W-1:0]   out_seq_q;
	logic                         out_erase_q;
	logic                         out_found_q;
	logic [frli_pkg::COUNT_W-1:0] out_count_q;
	logic [frli_pkg::SEQ_W-1:0]   out_oldest_q;
	logic [frli_pkg::SEQ_W-1:0]   out_latest_q;

	// Slot table.
	logic [frli_pkg::SEQ_W-1:0] mem [MAX_SLOTS];
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic [frli_pkg::SEQ_W-1:0] mem_wd;

	// Scan results.
	frli_pkg::scan_ctl_t        scan_ctl;
	logic [NW-1:0]              sc_count;
	logic [frli_pkg::SEQ_W-1:0] sc_oldest;
	logic [frli_pkg::SEQ_W-1:0] sc_latest;
	logic [frli_pkg::SEQ_W-1:0] sc_find_seq;
	logic [AW-1:0]              sc_find_slot;

	logic req_go;
	logic fin_go;

	// Slots in use: sector count (zero read as one) times sector size, capped.
	logic [frli_pkg::SECT_W-1:0] sectors;
	logic [PW-1:0]               prod;
	logic [NW-1:0]               n;

	assign sectors = (sect_q == '0) ? frli_pkg::SECT_W'(1) : sect_q;
	assign prod    = PW'(sectors) * PW'(SLOTS_PER_SECTOR);
	assign n       = (prod > PW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(prod);

	// Append slot choice: wrap a stale next slot, then skip a used partial sector.
	logic          ns_wrap;
	logic [AW-1:0] s0;
	logic [OW-1:0] o0;
	logic          skip;
	logic [JW-1:0] jump;
	logic [AW-1:0] s1;
	logic [OW-1:0] o1;

	always_comb begin
		ns_wrap = NW'(next_slot_q) >= n;
		s0      = ns_wrap ? '0 : next_slot_q;
		o0      = ns_wrap ? '0 : off_q;
		skip    = (o0 != '0) && !blank_q;
		jump    = JW'(s0) - JW'(o0) + JW'(SLOTS_PER_SECTOR);
		if (skip) begin
			s1 = (jump >= JW'(n)) ? '0 : AW'(jump);
			o1 = '0;
		end else begin
			s1 = s0;
			o1 = o0;
		end
	end

	// Restore bookkeeping.
	logic [XW-1:0] sidx_x;
	logic          rs_in_range;
	logic          rs_newer;
	logic [XW-1:0] rs_next;
	logic [AW-1:0] rs_next_slot;

	always_comb begin
		sidx_x       = XW'(sidx_q);
		rs_in_range  = sidx_x < XW'(n);
		rs_newer     = val_q > newest_q;
		rs_next      = sidx_x + XW'(1);
		rs_next_slot = (rs_next >= XW'(n)) ? '0 : AW'(rs_next);
	end

	// Sector erase walk and the slot after an append.
	logic [NW-1:0] erase_addr;
	logic          erase_last;
	logic [NW-1:0] wr_next;

	always_comb begin
		erase_addr = NW'(wslot_q) + NW'(clr_q);
		erase_last = (clr_q == OFF_LAST) || (erase_addr == (n - NW'(1)));
		wr_next    = NW'(wslot_q) + NW'(1);
	end

	assign req_go = req.valid && req.ready;
	assign fin_go = !rsp_valid_q || rsp.ready;

	// Table write port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = scan_q;
			end
			ST_PREP: begin
				if ((mode_q == frli_pkg::MODE_RESTORE) && rs_in_range) begin
					mem_we = 1'b1;
					mem_wa = sidx_x[AW-1:0];
					mem_wd = val_q;
				end
			end
			ST_ERASE: begin
				mem_we = 1'b1;
				mem_wa = erase_addr[AW-1:0];
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_wa = wslot_q;
				mem_wd = next_seq_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Memory with registered read; the read address is the sweep counter.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1  <= mem[scan_q];
		idx_s1 <= scan_q;
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sect_q      <= frli_pkg::SECT_RESET;
			next_slot_q <= '0;
			off_q       <= '0;
			next_seq_q  <= frli_pkg::SEQ_FIRST;
			newest_q    <= '0;
			scan_q      <= '0;
			off_run_q   <= '0;
			clr_q       <= '0;
			take_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				sect_q <= cfg.sector_count;
			end
			take_s1 <= (state_q == ST_SCAN);
			// A new result is presented once the output is free; otherwise a transfer empties it.
			if ((state_q == ST_FIN) && fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (scan_q == CLEAR_LAST) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (req_go) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					scan_q    <= '0;
					off_run_q <= '0;
					clr_q     <= '0;
					if (mode_q == frli_pkg::MODE_APPEND) begin
						state_q <= (o1 == '0) ? ST_ERASE : ST_WRITE;
					end else begin
						state_q <= ST_SCAN;
					end
					if ((mode_q == frli_pkg::MODE_RESTORE) && rs_in_range && rs_newer) begin
						newest_q    <= val_q;
						next_seq_q  <= frli_pkg::seq_after(val_q);
						next_slot_q <= rs_next_slot;
					end
				end
				ST_ERASE: begin
					clr_q <= clr_q + OW'(1);
					if (erase_last) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					next_seq_q  <= frli_pkg::seq_after(next_seq_q);
					next_slot_q <= (wr_next >= n) ? '0 : AW'(wr_next);
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					// The offset of the next slot in its sector is picked up on the way.
					if (scan_q == next_slot_q) begin
						off_q <= off_run_q;
					end
					off_run_q <= (off_run_q == OFF_LAST) ? '0 : off_run_q + OW'(1);
					if (NW'(scan_q) == (n - NW'(1))) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, append choice and output registers.
	always_ff @(posedge clk) begin
		if (req_go) begin
			mode_q  <= req.mode;
			sidx_q  <= req.slot_index;
			val_q   <= req.sequence_value;
			blank_q <= req.slot_blank;
		end
		if (state_q == ST_PREP) begin
			wslot_q <= s1;
			erase_q <= (o1 == '0);
		end
		if (state_q == ST_WRITE) begin
			aseq_q <= next_seq_q;
		end
		if ((state_q == ST_FIN) && fin_go) begin
			out_count_q  <= frli_pkg::COUNT_W'(sc_count);
			out_oldest_q <= sc_oldest;
			out_latest_q <= sc_latest;
			case (mode_q)
				frli_pkg::MODE_APPEND: begin
					out_slot_q  <= frli_pkg::SLOT_W'(wslot_q);
					out_seq_q   <= aseq_q;
					out_erase_q <= erase_q;
					out_found_q <= 1'b0;
				end
				frli_pkg::MODE_FIND: begin
					out_slot_q  <= frli_pkg::SLOT_W'(sc_find_slot);
					out_seq_q   <= sc_find_seq;
					out_erase_q <= 1'b0;
					out_found_q <= (sc_find_seq != '0);
				end
				frli_pkg::MODE_RESTORE: begin
					out_slot_q  <= frli_pkg::SLOT_W'(next_slot_q);
					out_seq_q   <= next_seq_q;
					out_erase_q <= 1'b0;
					out_found_q <= 1'b0;
				end
				default: begin
					out_slot_q  <= '0;
					out_seq_q   <= '0;
					out_erase_q <= 1'b0;
					out_found_q <= 1'b0;
				end
			endcase
		end
	end

	// Sweep accumulator.
	assign scan_ctl.start = (state_q == ST_PREP);
	assign scan_ctl.take  = take_s1;

	frli_scan #(
		.AW (AW),
		.NW (NW)
	) u_scan (
		.clk       (clk),
		.ctl       (scan_ctl),
		.data      (rd_s1),
		.idx       (idx_s1),
		.bound     (val_q),
		.count     (sc_count),
		.oldest    (sc_oldest),
		.latest    (sc_latest),
		.find_seq  (sc_find_seq),
		.find_slot (sc_find_slot)
	);

	// Port drive.
	assign req.ready           = (state_q == ST_IDLE);
	assign cfg.ready           = 1'b1;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.result_slot     = out_slot_q;
	assign rsp.result_sequence = out_seq_q;
	assign rsp.erase_needed    = out_erase_q;
	assign rsp.found           = out_found_q;
	assign rsp.valid_count     = out_count_q;
	assign rsp.min_sequence    = out_oldest_q;
	assign rsp.max_sequence    = out_latest_q;

	// An accepted request always starts in the preparation step.
	a_req_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		req_go |=> (state_q == ST_PREP))
		else $error("accepted request did not enter preparation");

	// The sweep reads the table and must never overlap a write.
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("table write during sweep");

	// The erase walk ends in the slot write.
	a_erase_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ERASE) && erase_last) |=> (state_q == ST_WRITE))
		else $error("erase walk did not end in the slot write");

	// After an append the next slot lies inside the slots in use.
	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (NW'(next_slot_q) < $past(n)))
		else $error("next slot beyond slots in use after append");

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;

	localparam int TABLE_SLOTS  = 1024;
	localparam int SECTOR_SLOTS = 32;
	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_CYCLES = 1200;

	localparam logic KNOWN     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [frli_pkg::MODE_W-1:0] mode;
		logic [frli_pkg::SLOT_W-1:0] slot_index;
		logic [frli_pkg::SEQ_W-1:0]  seq;
		logic                        blank;
	} log_op_t;

	typedef struct packed {
		logic [frli_pkg::SLOT_W-1:0]  slot;
		logic [frli_pkg::SEQ_W-1:0]   seq;
		logic                         erase;
		logic                         found;
		logic [frli_pkg::COUNT_W-1:0] count;
		logic [frli_pkg::SEQ_W-1:0]   oldest;
		logic [frli_pkg::SEQ_W-1:0]   latest;
	} log_result_t;

	typedef struct packed {
		log_op_t     op;
		logic        known;
		log_result_t want;
	} dir_row_t;

	typedef struct packed {
		logic [frli_pkg::SECT_W-1:0] sectors;
		logic [9:0]                  items;
		logic [6:0]                  send_idle;
		logic [6:0]                  recv_stall;
		logic                        long_hold;
	} phase_t;

	// Opening rows run with the reset sector count (896 slots in use).
	localparam dir_row_t DIRECTED [20] = '{
		'{'{frli_pkg::MODE_NOP,     10'd0,    32'h0,        1'b0}, KNOWN,
			'{10'd0,  32'h0, 1'b0, 1'b0, 11'd0, 32'h0, 32'h0}},
		'{'{frli_pkg::MODE_FIND,    10'd0,    32'h0,        1'b0}, KNOWN,
			'{10'd0,  32'h0, 1'b0, 1'b0, 11'd0, 32'h0, 32'h0}},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b1}, KNOWN,
			'{10'd0,  32'h1, 1'b1, 1'b0, 11'd1, 32'h1, 32'h1}},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b0}, KNOWN,
			'{10'd32, 32'h2, 1'b1, 1'b0, 11'd2, 32'h1, 32'h2}},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b1}, KNOWN,
			'{10'd33, 32'h3, 1'b0, 1'b0, 11'd3, 32'h1, 32'h3}},
		'{'{frli_pkg::MODE_FIND,    10'd0,    32'h1,        1'b0}, KNOWN,
			'{10'd32, 32'h2, 1'b0, 1'b1, 11'd3, 32'h1, 32'h3}},
		'{'{frli_pkg::MODE_FIND,    10'd0,    32'hFFFFFFFF, 1'b1}, KNOWN,
			'{10'd0,  32'h0, 1'b0, 1'b0, 11'd3, 32'h1, 32'h3}},
		'{'{frli_pkg::MODE_RESTORE, 10'd1023, 32'hFFFFFFFF, 1'b0}, KNOWN,
			'{10'd34, 32'h4, 1'b0, 1'b0, 11'd3, 32'h1, 32'h3}},
		'{'{frli_pkg::MODE_RESTORE, 10'd100,  32'h0,        1'b1}, KNOWN,
			'{10'd34, 32'h4, 1'b0, 1'b0, 11'd3, 32'h1, 32'h3}},
		'{'{frli_pkg::MODE_RESTORE, 10'd200,  32'h10,       1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_RESTORE, 10'd300,  32'h5,        1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_RESTORE, 10'd895,  32'hFFFFFFFE, 1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_APPEND,  10'd0,    32'h0,        1'b1}, PREDICTED, '0},
		'{'{frli_pkg::MODE_FIND,    10'd0,    32'h0,        1'b1}, PREDICTED, '0},
		'{'{frli_pkg::MODE_RESTORE, 10'd0,    32'h0,        1'b0}, PREDICTED, '0},
		'{'{frli_pkg::MODE_RESTORE, 10'd895,  32'hFFFFFFFF, 1'b1}, PREDICTED, '0},
		'{'{frli_pkg::MODE_NOP,     10'd1023, 32'hFFFFFFFF, 1'b1}, PREDICTED, '0},
		'{'{frli_pkg::MODE_FIND,    10'd1023, 32'hFFFFFFFE, 1'b0}, PREDICTED, '0}
	};

	// Random phases: most run with few sectors to keep the table sweep short.
	localparam phase_t PHASES [10] = '{
		'{6'd1,  10'd80, 7'd0,  7'd0,  1'b0},
		'{6'd2,  10'd80, 7'd58, 7'd0,  1'b0},
		'{6'd4,  10'd80, 7'd0,  7'd58, 1'b0},
		'{6'd3,  10'd70, 7'd7,  7'd7,  1'b0},
		'{6'd0,  10'd50, 7'd7,  7'd7,  1'b0},
		'{6'd32, 10'd25, 7'd0,  7'd0,  1'b0},
		'{6'd63, 10'd15, 7'd58, 7'd0,  1'b0},
		'{6'd2,  10'd60, 7'd0,  7'd58, 1'b1},
		'{6'd5,  10'd50, 7'd0,  7'd0,  1'b0},
		'{6'd6,  10'd40, 7'd7,  7'd7,  1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	frli_req_if req_ch ();
	frli_rsp_if rsp_ch ();
	frli_cfg_if cfg_ch ();

	flash_ring_log_index_unit #(
		.MAX_SLOTS        (TABLE_SLOTS),
		.SLOTS_PER_SECTOR (SECTOR_SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the index state.
	logic [frli_pkg::SEQ_W-1:0]  seq_store [TABLE_SLOTS];
	int unsigned                 nxt_slot;
	logic [frli_pkg::SEQ_W-1:0]  nxt_seq;
	logic [frli_pkg::SEQ_W-1:0]  newest_restored;
	logic [frli_pkg::SECT_W-1:0] sect_reg;

	log_result_t pending_results [$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_orders = 0;
	int          quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned live_slots();
		int unsigned sectors;
		sectors = (sect_reg == '0) ? 1 : int'(sect_reg);
		return (sectors * SECTOR_SLOTS > TABLE_SLOTS) ? TABLE_SLOTS : sectors * SECTOR_SLOTS;
	endfunction

	// Applies one operation to the shadow state and returns the result it yields.
	function automatic log_result_t log_index_step(input log_op_t op);
		int unsigned n;
		int unsigned i;
		log_result_t r;
		logic [frli_pkg::SEQ_W-1:0] s;
		n = live_slots();
		r = '0;
		case (op.mode)
		frli_pkg::MODE_APPEND: begin
			if (nxt_slot >= n)
				nxt_slot = 0;
			// A used slot inside a sector sends the write on to the next sector.
			if (nxt_slot % SECTOR_SLOTS != 0 && !op.blank) begin
				nxt_slot = (nxt_slot / SECTOR_SLOTS + 1) * SECTOR_SLOTS;
				if (nxt_slot >= n)
					nxt_slot = 0;
			end
			if (nxt_slot % SECTOR_SLOTS == 0) begin
				r.erase = 1'b1;
				for (i = 0; i < SECTOR_SLOTS && nxt_slot + i < n; i++)
					seq_store[nxt_slot + i] = '0;
			end
			r.slot = frli_pkg::SLOT_W'(nxt_slot);
			r.seq = nxt_seq;
			nxt_seq = (nxt_seq == '1) ? frli_pkg::SEQ_FIRST : nxt_seq + 1'b1;
			seq_store[nxt_slot] = r.seq;
			nxt_slot = nxt_slot + 1;
			if (nxt_slot >= n)
				nxt_slot = 0;
		end
		frli_pkg::MODE_FIND: begin
			for (i = 0; i < n; i++) begin
				s = seq_store[i];
				if (s > op.seq && (r.seq == '0 || s < r.seq)) begin
					r.seq = s;
					r.slot = frli_pkg::SLOT_W'(i);
				end
			end
			r.found = (r.seq != '0);
		end
		frli_pkg::MODE_RESTORE: begin
			// Slots outside the region in use are left alone.
			if (op.slot_index < n) begin
				seq_store[op.slot_index] = op.seq;
				if (op.seq > newest_restored) begin
					newest_restored = op.seq;
					nxt_seq = (op.seq == '1) ? frli_pkg::SEQ_FIRST : op.seq + 1'b1;
					nxt_slot = int'(op.slot_index) + 1;
					if (nxt_slot >= n)
						nxt_slot = 0;
				end
			end
			r.slot = frli_pkg::SLOT_W'(nxt_slot);
			r.seq = nxt_seq;
		end
		default: begin
		end
		endcase
		// Summary over the slots in use.
		for (i = 0; i < n; i++) begin
			s = seq_store[i];
			if (s != '0) begin
				r.count = r.count + 1'b1;
				if (r.oldest == '0 || s < r.oldest)
					r.oldest = s;
				if (s > r.latest)
					r.latest = s;
			end
		end
		return r;
	endfunction

	// Offers one operation, with random idle cycles first, and records its expectation.
	task automatic send_op(input log_op_t op, input logic known, input log_result_t want);
		log_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.mode           <= op.mode;
		req_ch.slot_index     <= op.slot_index;
		req_ch.sequence_value <= op.seq;
		req_ch.slot_blank     <= op.blank;
		do
			@(posedge clk);
		while (!req_ch.ready);
		r = log_index_step(op);
		pending_results.push_back(known ? want : r);
	endtask

	// The sector count is only changed once every result has come back.
	task automatic write_sector_count(input logic [frli_pkg::SECT_W-1:0] value);
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.sector_count <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sect_reg = value;
	endtask

	// Result side: random stalls, and a long hold-off whenever one is ordered.
	initial begin
		int holds_done;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_orders != holds_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				holds_done++;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result transfer with the oldest outstanding expectation.
	always @(posedge clk) begin
		log_result_t due;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expectation pending");
				mismatches++;
			end else begin
				due = pending_results.pop_front();
				if (rsp_ch.result_slot !== due.slot) begin
					$error("result_slot: expected %0d, got %0d", due.slot, rsp_ch.result_slot);
					mismatches++;
				end
				if (rsp_ch.result_sequence !== due.seq) begin
					$error("result_sequence: expected %0h, got %0h", due.seq,
						rsp_ch.result_sequence);
					mismatches++;
				end
				if (rsp_ch.erase_needed !== due.erase) begin
					$error("erase_needed: expected %0d, got %0d", due.erase,
						rsp_ch.erase_needed);
					mismatches++;
				end
				if (rsp_ch.found !== due.found) begin
					$error("found: expected %0d, got %0d", due.found, rsp_ch.found);
					mismatches++;
				end
				if (rsp_ch.valid_count !== due.count) begin
					$error("valid_count: expected %0d, got %0d", due.count, rsp_ch.valid_count);
					mismatches++;
				end
				if (rsp_ch.min_sequence !== due.oldest) begin
					$error("min_sequence: expected %0h, got %0h", due.oldest,
						rsp_ch.min_sequence);
					mismatches++;
				end
				if (rsp_ch.max_sequence !== due.latest) begin
					$error("max_sequence: expected %0h, got %0h", due.latest,
						rsp_ch.max_sequence);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL flash_ring_log_index_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed rows, then the random phases.
	initial begin
		log_op_t op;
		int unsigned pick;
		foreach (seq_store[k])
			seq_store[k] = '0;
		nxt_slot = 0;
		nxt_seq = frli_pkg::SEQ_FIRST;
		newest_restored = '0;
		sect_reg = frli_pkg::SECT_RESET;

		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.mode           <= frli_pkg::MODE_NOP;
		req_ch.slot_index     <= '0;
		req_ch.sequence_value <= '0;
		req_ch.slot_blank     <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.sector_count   <= frli_pkg::SECT_RESET;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[k])
			send_op(DIRECTED[k].op, DIRECTED[k].known, DIRECTED[k].want);
		req_ch.valid <= 1'b0;

		foreach (PHASES[p]) begin
			send_idle_pct = PHASES[p].send_idle;
			recv_stall_pct = PHASES[p].recv_stall;
			write_sector_count(PHASES[p].sectors);
			if (PHASES[p].long_hold)
				hold_orders++;
			repeat (PHASES[p].items) begin
				pick = $urandom_range(0, 99);
				op.slot_index = frli_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
				op.seq = $urandom;
				op.blank = ($urandom_range(0, 3) != 0);
				if (pick < 55) begin
					op.mode = frli_pkg::MODE_APPEND;
				end else if (pick < 80) begin
					// Bounds often just below recently issued sequences, else zero or random.
					op.mode = frli_pkg::MODE_FIND;
					case ($urandom_range(0, 3))
					0: op.seq = '0;
					1, 2: op.seq = nxt_seq - frli_pkg::SEQ_W'($urandom_range(1, 60));
					default: begin
					end
					endcase
				end else if (pick < 92) begin
					op.mode = frli_pkg::MODE_RESTORE;
					if ($urandom_range(0, 9) != 0)
						op.slot_index = frli_pkg::SLOT_W'($urandom_range(0, live_slots() - 1));
					case ($urandom_range(0, 4))
					0: op.seq = '0;
					1, 2, 3: op.seq = nxt_seq - frli_pkg::SEQ_W'($urandom_range(1, 200));
					default: begin
					end
					endcase
				end else begin
					op.mode = frli_pkg::MODE_NOP;
				end
				send_op(op, PREDICTED, '0);
			end
			req_ch.valid <= 1'b0;
		end

		// Let the last results drain, then a margin for anything unexpected.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("PASS flash_ring_log_index_unit");
		else
			$display("FAIL flash_ring_log_index_unit");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/frli_pkg.sv
rtl/frli_if.sv
rtl/frli_scan.sv
rtl/flash_ring_log_index_unit.sv
sim/tb.sv
